// ----- rtl/samavg_pkg.sv -----
package samavg_pkg;

  localparam int WINDOW   = 10;
  localparam int AXES     = 6;
  localparam int SAMPLE_W = 16;
  localparam int OFFS_N   = 3;

  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int RECIP_L  = $clog2(WINDOW);
  localparam int RECIP_SH = SUM_W + RECIP_L;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Z = 2'd2;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_set_t;

  typedef struct packed {
    logic                       data_ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg_accel_x;
    logic signed [SAMPLE_W-1:0] avg_accel_y;
    logic signed [SAMPLE_W-1:0] avg_accel_z;
    logic signed [SAMPLE_W-1:0] avg_gyro_x;
    logic signed [SAMPLE_W-1:0] avg_gyro_y;
    logic signed [SAMPLE_W-1:0] avg_gyro_z;
  } out_item_t;

endpackage

// ----- rtl/samavg_cell.sv -----
module samavg_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  samavg_pkg::sample_set_t  d,
  output samavg_pkg::sample_set_t  q
);

  samavg_pkg::sample_set_t data_r;
  samavg_pkg::sample_set_t data_nxt;

  always_comb begin
    data_nxt = shift_en ? d : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign q = data_r;

endmodule

// ----- rtl/samavg_div.sv -----
module samavg_div (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [samavg_pkg::SUM_W-1:0]      sum,
  output logic        [samavg_pkg::SAMPLE_W-1:0]   quot
);

  logic [samavg_pkg::SUM_W-1:0]    mag;
  logic [samavg_pkg::PROD_W-1:0]   prod_r;
  logic [samavg_pkg::PROD_W-1:0]   prod_nxt;
  logic                            neg_r;
  logic                            neg_nxt;
  logic [samavg_pkg::SAMPLE_W-1:0] quot_mag;

  // The magnitude is multiplied by a rounded-up reciprocal of the window
  // length, which gives the exact floor quotient for every dividend width used.
  always_comb begin
    mag      = sum[samavg_pkg::SUM_W-1] ? (-sum) : sum;
    prod_nxt = en ? (samavg_pkg::PROD_W'(mag) * samavg_pkg::PROD_W'(samavg_pkg::RECIP_M))
                  : prod_r;
    neg_nxt  = en ? sum[samavg_pkg::SUM_W-1] : neg_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= neg_nxt;
  end

  assign quot_mag = prod_r[samavg_pkg::RECIP_SH +: samavg_pkg::SAMPLE_W];
  assign quot     = neg_r ? (-quot_mag) : quot_mag;

endmodule

// ----- rtl/six_axis_moving_average.sv -----
// Throughput: one item per cycle while out_stall is low. The window is a chain of
// shift cells with a running sum per axis, followed by a reciprocal multiply stage
// and an output register; a result is valid once its item has passed each in turn.
// Reset clears the window, running sums and held averages to zero and the gyro
// offsets to zero; no clearing pass is needed.
module six_axis_moving_average (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  samavg_pkg::in_item_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output samavg_pkg::out_item_t                  out_data,
  input  logic                                   cfg_we,
  input  logic [samavg_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [samavg_pkg::SAMPLE_W-1:0]        cfg_wdata
);

  localparam int SW = samavg_pkg::SAMPLE_W;
  localparam int NW = samavg_pkg::SUM_W;
  localparam int NA = samavg_pkg::AXES;

  samavg_pkg::sample_set_t new_set;
  samavg_pkg::sample_set_t cell_q [samavg_pkg::WINDOW];

  logic in_acc;
  logic shift_en;
  logic v0_r, v0_nxt, upd0_r, upd0_nxt;
  logic v1_r, v1_nxt, upd1_r, upd1_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv2, ready1, ready0, move0, take1;

  logic signed [NW-1:0] sum_r   [NA];
  logic signed [NW-1:0] sum_nxt [NA];
  logic        [SW-1:0] quot    [NA];
  logic        [SW-1:0] held_r  [NA];
  logic        [SW-1:0] held_nxt[NA];
  logic        [SW-1:0] avg_sel [NA];
  logic        [SW-1:0] offs_r  [samavg_pkg::OFFS_N];
  logic        [SW-1:0] offs_nxt[samavg_pkg::OFFS_N];

  samavg_pkg::out_item_t out_data_r;
  samavg_pkg::out_item_t out_data_nxt;

  function automatic logic signed [NW-1:0] sext(input logic [SW-1:0] x);
    return {{(NW - SW){x[SW-1]}}, x};
  endfunction

  assign new_set[0] = in_data.accel_x;
  assign new_set[1] = in_data.accel_y;
  assign new_set[2] = in_data.accel_z;
  assign new_set[3] = in_data.gyro_x;
  assign new_set[4] = in_data.gyro_y;
  assign new_set[5] = in_data.gyro_z;

  assign adv2     = !out_valid_r || !out_stall;
  assign ready1   = !v1_r || adv2;
  assign ready0   = !v0_r || ready1;
  assign move0    = v0_r && ready1;
  assign take1    = v1_r && adv2;
  assign in_stall = !ready0;
  assign in_acc   = in_valid && ready0;
  assign shift_en = in_acc && in_data.data_ready;

  for (genvar i = 0; i < samavg_pkg::WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      samavg_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d        (new_set),
        .q        (cell_q[i])
      );
    end else begin : g_body
      samavg_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d        (cell_q[i-1]),
        .q        (cell_q[i])
      );
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis
    samavg_div u_div (
      .clk  (clk),
      .en   (move0),
      .sum  (sum_r[a]),
      .quot (quot[a])
    );
  end

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      sum_nxt[a] = shift_en
        ? (sum_r[a] + sext(new_set[a]) - sext(cell_q[samavg_pkg::WINDOW-1][a]))
        : sum_r[a];
      avg_sel[a]  = upd1_r ? quot[a] : held_r[a];
      held_nxt[a] = take1 ? avg_sel[a] : held_r[a];
    end
  end

  always_comb begin
    v0_nxt   = in_acc ? 1'b1 : (move0 ? 1'b0 : v0_r);
    upd0_nxt = in_acc ? in_data.data_ready : upd0_r;
    v1_nxt   = move0 ? 1'b1 : (take1 ? 1'b0 : v1_r);
    upd1_nxt = move0 ? upd0_r : upd1_r;
    out_valid_nxt = take1 ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_comb begin
    for (int k = 0; k < samavg_pkg::OFFS_N; k++) begin
      offs_nxt[k] = offs_r[k];
    end
    if (cfg_we) begin
      case (cfg_idx)
        samavg_pkg::REG_GYRO_OFFSET_X: offs_nxt[0] = cfg_wdata;
        samavg_pkg::REG_GYRO_OFFSET_Y: offs_nxt[1] = cfg_wdata;
        samavg_pkg::REG_GYRO_OFFSET_Z: offs_nxt[2] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (take1) begin
      out_data_nxt.avg_accel_x = avg_sel[0];
      out_data_nxt.avg_accel_y = avg_sel[1];
      out_data_nxt.avg_accel_z = avg_sel[2];
      out_data_nxt.avg_gyro_x  = avg_sel[3] - offs_r[0];
      out_data_nxt.avg_gyro_y  = avg_sel[4] - offs_r[1];
      out_data_nxt.avg_gyro_z  = avg_sel[5] - offs_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      upd0_r      <= 1'b0;
      v1_r        <= 1'b0;
      upd1_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        sum_r[a]  <= '0;
        held_r[a] <= '0;
      end
      for (int k = 0; k < samavg_pkg::OFFS_N; k++) begin
        offs_r[k] <= '0;
      end
    end else begin
      v0_r        <= v0_nxt;
      upd0_r      <= upd0_nxt;
      v1_r        <= v1_nxt;
      upd1_r      <= upd1_nxt;
      out_valid_r <= out_valid_nxt;
      for (int a = 0; a < NA; a++) begin
        sum_r[a]  <= sum_nxt[a];
        held_r[a] <= held_nxt[a];
      end
      for (int k = 0; k < samavg_pkg::OFFS_N; k++) begin
        offs_r[k] <= offs_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
